/* src/lph_pkg.sv */
package lph_pkg;

   // Table geometry
   localparam int TABLE_LOG2 = 10;
   localparam int SLOTS      = 1 << TABLE_LOG2;

   // Fixed field widths
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;

   typedef logic [TABLE_LOG2-1:0] addr_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [KIND_W-1:0]     kind_type;

   // All-ones pattern marks an empty slot
   localparam value_type EMPTY_MARK = '1;

   // Request kinds
   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_LOOKUP = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_NOSLOT  = 2'd3
   } status_type;

   // Work handed from the front end to the table engine
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_REMOVE,
      OP_REPLY
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
      value_type  value;
      addr_type   addr;
   } cmd_type;

endpackage

/* src/lph_if.sv */
interface lph_req_if;
   logic                 valid;
   logic                 ready;
   lph_pkg::kind_type    kind;
   logic signed [31:0]   value;
   lph_pkg::slot_type    slot;

   modport source (output valid, output kind, output value, output slot, input ready);
   modport sink   (input valid, input kind, input value, input slot, output ready);
endinterface

interface lph_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic              found;
   lph_pkg::slot_type placed_slot;

   modport source (output valid, output status, output found, output placed_slot,
                   input ready);
   modport sink   (input valid, input status, input found, input placed_slot,
                   output ready);
endinterface

/* src/lph_front.sv */
module lph_front (
   lph_req_if.sink          req,
   input  logic             queue_full,
   output logic             push,
   output lph_pkg::cmd_type cmd
);

   logic is_empty_mark;
   logic out_of_range;

   assign req.ready     = !queue_full;
   assign push          = req.valid && !queue_full;
   assign is_empty_mark = (lph_pkg::value_type'(req.value) == lph_pkg::EMPTY_MARK);
   assign out_of_range  = (32'(req.slot) >= 32'(lph_pkg::SLOTS));

   // Settle trivial outcomes here; they still pass to the engine as ready-made replies
   always_comb begin
      cmd.value  = lph_pkg::value_type'(req.value);
      cmd.addr   = lph_pkg::addr_type'(req.value);
      cmd.status = lph_pkg::STATUS_OK;
      cmd.op     = lph_pkg::OP_REPLY;
      case (req.kind)
         lph_pkg::KIND_INSERT: begin
            if (is_empty_mark) begin
               cmd.status = lph_pkg::STATUS_INVALID;
            end else begin
               cmd.op = lph_pkg::OP_INSERT;
            end
         end
         lph_pkg::KIND_LOOKUP: begin
            if (is_empty_mark) begin
               cmd.status = lph_pkg::STATUS_INVALID;
            end else begin
               cmd.op = lph_pkg::OP_LOOKUP;
            end
         end
         lph_pkg::KIND_REMOVE: begin
            cmd.addr = lph_pkg::addr_type'(req.slot);
            if (out_of_range) begin
               cmd.status = lph_pkg::STATUS_NOSLOT;
            end else begin
               cmd.op = lph_pkg::OP_REMOVE;
            end
         end
         default: begin
            cmd.op = lph_pkg::OP_REPLY;
         end
      endcase
   end

endmodule

/* src/lph_fifo.sv */
module lph_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lph_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output lph_pkg::cmd_type head_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lph_pkg::cmd_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Report full while in reset so no transfer is taken and then dropped
   assign full       = (count_ff == CNT_W'(DEPTH)) || reset;
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = PTR_W'((32'(wptr_ff) + 1) % DEPTH);
      end
      if (pop) begin
         rptr_in = PTR_W'((32'(rptr_ff) + 1) % DEPTH);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/lph_engine.sv */
module lph_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lph_pkg::cmd_type cmd,
   output logic             pop,
   lph_rsp_if.source        rsp
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_REMOVE
   } state_type;

   lph_pkg::value_type  mem [lph_pkg::SLOTS];
   lph_pkg::value_type  rd_data_ff;

   state_type           state_ff, state_in;
   lph_pkg::addr_type   clr_ff, clr_in;
   lph_pkg::addr_type   pos_ff, pos_in;
   lph_pkg::addr_type   count_ff, count_in;
   lph_pkg::op_type     op_ff, op_in;
   lph_pkg::value_type  value_ff, value_in;
   logic                out_valid_ff, out_valid_in;
   lph_pkg::status_type status_ff, status_in;
   logic                found_ff, found_in;
   lph_pkg::slot_type   placed_ff, placed_in;

   lph_pkg::addr_type   rd_addr;
   logic                wr_en;
   lph_pkg::addr_type   wr_addr;
   lph_pkg::value_type  wr_data;
   logic                hit_empty;
   logic                hit_equal;

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.found       = found_ff;
   assign rsp.placed_slot = placed_ff;

   assign hit_empty = (rd_data_ff == lph_pkg::EMPTY_MARK);
   assign hit_equal = (rd_data_ff == value_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      status_in    = status_ff;
      found_in     = found_ff;
      placed_in    = placed_ff;
      pop          = 1'b0;
      rd_addr      = pos_ff + 1'b1;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = value_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = lph_pkg::EMPTY_MARK;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Start only with the result register free; it stays ours until done
            if (cmd_valid && !out_valid_ff) begin
               pop      = 1'b1;
               op_in    = cmd.op;
               value_in = cmd.value;
               pos_in   = cmd.addr;
               count_in = '0;
               rd_addr  = cmd.addr;
               case (cmd.op)
                  lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP: begin
                     state_in = S_PROBE;
                  end
                  lph_pkg::OP_REMOVE: begin
                     state_in = S_REMOVE;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     status_in    = cmd.status;
                     found_in     = 1'b0;
                     placed_in    = '0;
                  end
               endcase
            end
         end
         S_PROBE: begin
            // rd_data_ff holds the entry at pos_ff; next slot is already being read
            if (op_ff == lph_pkg::OP_INSERT && hit_empty) begin
               wr_en        = 1'b1;
               out_valid_in = 1'b1;
               status_in    = lph_pkg::STATUS_OK;
               found_in     = 1'b0;
               placed_in    = lph_pkg::slot_type'(pos_ff);
               state_in     = S_IDLE;
            end else if (op_ff == lph_pkg::OP_LOOKUP && hit_equal) begin
               out_valid_in = 1'b1;
               status_in    = lph_pkg::STATUS_OK;
               found_in     = 1'b1;
               placed_in    = '0;
               state_in     = S_IDLE;
            end else if (&count_ff) begin
               out_valid_in = 1'b1;
               status_in    = (op_ff == lph_pkg::OP_INSERT) ? lph_pkg::STATUS_FULL
                                                            : lph_pkg::STATUS_OK;
               found_in     = 1'b0;
               placed_in    = '0;
               state_in     = S_IDLE;
            end else begin
               pos_in   = pos_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         S_REMOVE: begin
            out_valid_in = 1'b1;
            found_in     = 1'b0;
            placed_in    = '0;
            state_in     = S_IDLE;
            if (hit_empty) begin
               status_in = lph_pkg::STATUS_NOSLOT;
            end else begin
               wr_en     = 1'b1;
               wr_data   = lph_pkg::EMPTY_MARK;
               status_in = lph_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      placed_ff <= placed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

/* src/linear_probe_hash_set_top.sv */
// Hash set of 32-bit signed values held in a 1024-slot single-port-read table with
// linear probing; a value's home slot is its low 10 bits and the all-ones pattern
// (-1) marks an empty slot. After reset the block sweeps the table to empty, one
// slot per cycle. req_chan holds ready low while reset is high and takes at most
// two transfers during the sweep; they wait in the queue until the sweep is done.
// The front end accepts a request whenever its two-entry queue has room, so new
// work is taken while a result still waits on rsp_chan. The engine takes a request
// off the queue at the earliest in the cycle after its transfer, and only once the
// previous result has left. Invalid values, unused kinds and out-of-range removes
// are answered through the result register without touching the table. Insert and
// membership test walk the table one slot per cycle, the rate of the single memory
// read port, until a slot settles it; a miss or a full table walks every slot.
// Remove reads the given slot and clears it if occupied. Items are served one at a
// time in order, and exactly one result comes back per request.
module linear_probe_hash_set_top (
   input logic        clock,
   input logic        reset,
   lph_req_if.sink    req_chan,
   lph_rsp_if.source  rsp_chan
);

   // Front end to queue
   logic             push;
   lph_pkg::cmd_type push_cmd;
   logic             queue_full;

   // Queue to engine
   logic             head_valid;
   lph_pkg::cmd_type head_cmd;
   logic             pop;

   // Classify each request and resolve the trivial replies
   lph_front u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // Decouple intake from the probe engine
   lph_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Own the table: clear sweep, probe sequencing, result register
   lph_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

/* sim/tb_linear_probe_hash_set_top.sv */
module tb_linear_probe_hash_set_top;

   // Kind code the block answers without touching the table
   localparam lph_pkg::kind_type KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 540;
   // Longest legal quiet stretch: reset sweep, a full-table probe and a long
   // receiver hold back to back; take it several times over
   localparam int STALL_LIMIT  = 12000;
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      lph_pkg::status_type status;
      logic                found;
      lph_pkg::slot_type   placed;
   } set_reply_type;

   logic clock = 1'b0;
   logic reset;

   lph_req_if req_chan();
   lph_rsp_if rsp_chan();

   linear_probe_hash_set_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table and the replies still owed by the block
   lph_pkg::value_type shadow_set [lph_pkg::SLOTS];
   int                 used_count;
   set_reply_type      pending_replies [$];

   int mismatches;
   int checked;
   int quiet_cycles;

   // Sender burst state and receiver hold request
   int burst_left;
   int idle_on;
   int rsp_hold_request;

   // Apply one request to the shadow table and return the reply it must give.
   // Insert takes the first empty slot from home; lookup scans the whole
   // table from home and never stops early on an empty slot.
   function automatic set_reply_type set_apply(input lph_pkg::kind_type k,
                                               input lph_pkg::value_type v,
                                               input lph_pkg::slot_type s);
      set_reply_type     r;
      lph_pkg::addr_type pos;
      r.status = lph_pkg::STATUS_OK;
      r.found  = 1'b0;
      r.placed = '0;
      case (k)
         lph_pkg::KIND_INSERT, lph_pkg::KIND_LOOKUP: begin
            if (v == lph_pkg::EMPTY_MARK) begin
               r.status = lph_pkg::STATUS_INVALID;
            end else begin
               pos = v[lph_pkg::TABLE_LOG2-1:0];
               if (k == lph_pkg::KIND_INSERT) r.status = lph_pkg::STATUS_FULL;
               for (int n = 0; n < lph_pkg::SLOTS; n++) begin
                  if (k == lph_pkg::KIND_INSERT && shadow_set[pos] == lph_pkg::EMPTY_MARK)
                  begin
                     shadow_set[pos] = v;
                     used_count++;
                     r.status = lph_pkg::STATUS_OK;
                     r.placed = pos;
                     break;
                  end
                  if (k == lph_pkg::KIND_LOOKUP && shadow_set[pos] == v) begin
                     r.found = 1'b1;
                     break;
                  end
                  pos = pos + 1'b1;
               end
            end
         end
         lph_pkg::KIND_REMOVE: begin
            if (shadow_set[s] == lph_pkg::EMPTY_MARK) begin
               r.status = lph_pkg::STATUS_NOSLOT;
            end else begin
               shadow_set[s] = lph_pkg::EMPTY_MARK;
               used_count--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Random value whose home slot is the given one; never the empty marker
   function automatic lph_pkg::value_type make_value(input lph_pkg::addr_type home);
      lph_pkg::value_type v;
      v = $urandom();
      v[lph_pkg::TABLE_LOG2-1:0] = home;
      if (v == lph_pkg::EMPTY_MARK) v[31] = 1'b0;
      return v;
   endfunction

   // First occupied slot at or after start; caller makes sure one exists
   function automatic lph_pkg::slot_type find_used(input lph_pkg::addr_type start);
      lph_pkg::addr_type pos;
      pos = start;
      for (int n = 0; n < lph_pkg::SLOTS; n++) begin
         if (shadow_set[pos] != lph_pkg::EMPTY_MARK) break;
         pos = pos + 1'b1;
      end
      return pos;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH result %0d: %s got %0h expected %0h", checked, what, got, want);
      mismatches++;
   endtask

   // Offer one request, hold it until the block takes it, then record the
   // reply it owes. Gaps between bursts keep valid low for whole cycles.
   task automatic send_item(input lph_pkg::kind_type k, input lph_pkg::value_type v,
                            input lph_pkg::slot_type s);
      int gap;
      if (burst_left == 0) begin
         gap = idle_on ? $urandom_range(1, 6) : 0;
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.kind  <= k;
      req_chan.value <= v;
      req_chan.slot  <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_replies.push_back(set_apply(k, v, s));
   endtask

   task automatic test_invalid_value();
      send_item(lph_pkg::KIND_INSERT, lph_pkg::EMPTY_MARK, '0);
      send_item(lph_pkg::KIND_LOOKUP, lph_pkg::EMPTY_MARK, 10'h3FF);
   endtask

   task automatic test_unused_kind();
      send_item(KIND_UNUSED, lph_pkg::EMPTY_MARK, 10'h3FF);
      send_item(KIND_UNUSED, 32'h0000_0000, '0);
   endtask

   // Collisions, wrap-around past the last slot, duplicates, hit and miss,
   // removes of full slots at both ends of the index range and of an empty one
   task automatic test_probe_basics();
      send_item(lph_pkg::KIND_INSERT, 32'h7FFF_FFFF, '0);
      send_item(lph_pkg::KIND_INSERT, 32'h8000_0000, '0);
      send_item(lph_pkg::KIND_INSERT, 32'h0000_0000, '0);
      send_item(lph_pkg::KIND_INSERT, 32'hFFFF_FFFE, 10'h3FF);
      send_item(lph_pkg::KIND_LOOKUP, 32'h0000_0000, '0);
      send_item(lph_pkg::KIND_LOOKUP, 32'h8000_0000, '0);
      send_item(lph_pkg::KIND_LOOKUP, 32'h0000_0005, '0);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd1);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd1);
      send_item(lph_pkg::KIND_REMOVE, lph_pkg::EMPTY_MARK, 10'd1023);
      send_item(lph_pkg::KIND_INSERT, 32'h0000_03FF, '0);
      send_item(lph_pkg::KIND_INSERT, 32'h0000_03FF, '0);
      send_item(lph_pkg::KIND_LOOKUP, 32'h0000_03FF, '0);
      send_item(lph_pkg::KIND_LOOKUP, 32'h0000_0000, '0);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd0);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd1);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd1022);
      send_item(lph_pkg::KIND_REMOVE, '0, 10'd1023);
   endtask

   // Hold the result side off while requests keep coming, so the front-end
   // queue fills and the block drops ready on its input
   task automatic test_output_stall();
      int saved_idle;
      saved_idle = idle_on;
      idle_on = 0;
      rsp_hold_request = HOLD_CYCLES;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 0)
            send_item(lph_pkg::KIND_INSERT, make_value(lph_pkg::addr_type'($urandom)), '0);
         else
            send_item(lph_pkg::KIND_REMOVE, $urandom(), lph_pkg::slot_type'($urandom));
      end
      idle_on = saved_idle;
   endtask

   // Mostly well-formed traffic on a clustered region of the table so probe
   // chains grow long and wrap; the rest is noise and unused kinds
   task automatic test_random_traffic();
      lph_pkg::addr_type window;
      lph_pkg::addr_type home;
      int                pick;
      window = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
            window  = $urandom_range(0, 1) ? lph_pkg::addr_type'(1000)
                                           : lph_pkg::addr_type'($urandom);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35 && used_count > 300) pick = 70;
         if (pick < 35) begin
            home = $urandom_range(0, 3) != 0
                   ? window + lph_pkg::addr_type'($urandom_range(0, 40))
                   : lph_pkg::addr_type'($urandom);
            send_item(lph_pkg::KIND_INSERT, make_value(home), lph_pkg::slot_type'($urandom));
         end else if (pick < 60) begin
            if (used_count > 0 && $urandom_range(0, 1))
               send_item(lph_pkg::KIND_LOOKUP,
                         shadow_set[find_used(lph_pkg::addr_type'($urandom))],
                         lph_pkg::slot_type'($urandom));
            else
               send_item(lph_pkg::KIND_LOOKUP, $urandom(), lph_pkg::slot_type'($urandom));
         end else if (pick < 85) begin
            if (used_count > 0 && $urandom_range(0, 4) != 0)
               send_item(lph_pkg::KIND_REMOVE, $urandom(),
                         find_used(lph_pkg::addr_type'($urandom)));
            else
               send_item(lph_pkg::KIND_REMOVE, $urandom(), lph_pkg::slot_type'($urandom));
         end else if (pick < 92) begin
            send_item($urandom_range(0, 1) ? lph_pkg::KIND_INSERT : lph_pkg::KIND_LOOKUP,
                      lph_pkg::EMPTY_MARK, lph_pkg::slot_type'($urandom));
         end else begin
            send_item(KIND_UNUSED, $urandom(), lph_pkg::slot_type'($urandom));
         end
      end
   endtask

   // Receiver: stall on one of four ready patterns, picked at random, and honor a
   // long hold when a test asks for one
   initial begin : rsp_drain
      int mode;
      int mode_left;
      int hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= (mode_left % 4 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest owed reply
   always @(posedge clock) begin : reply_check
      set_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(rsp_chan.status), '0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            if (rsp_chan.found !== want.found)
               report_mismatch("found", 32'(rsp_chan.found), 32'(want.found));
            if (rsp_chan.placed_slot !== want.placed)
               report_mismatch("placed_slot", 32'(rsp_chan.placed_slot), 32'(want.placed));
         end
         checked++;
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      mismatches       = 0;
      checked          = 0;
      quiet_cycles     = 0;
      burst_left       = 0;
      idle_on          = 1;
      rsp_hold_request = 0;
      used_count       = 0;
      foreach (shadow_set[i]) shadow_set[i] = lph_pkg::EMPTY_MARK;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.kind  <= lph_pkg::KIND_INSERT;
      req_chan.value <= '0;
      req_chan.slot  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its table after reset; send_item simply waits it out
      test_invalid_value();
      test_unused_kind();
      test_probe_basics();
      test_output_stall();
      test_random_traffic();

      req_chan.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
